// ----- design/button_edge_autorepeat_macros.svh -----
// Assertion macros shared by the button qualifier RTL.
`ifndef BUTTON_EDGE_AUTOREPEAT_MACROS_SVH
`define BUTTON_EDGE_AUTOREPEAT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BEA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bea same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BEA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bea next-cycle check failed");

`endif

// ----- design/bea_pkg.sv -----
// Types and constants for the button edge / auto-repeat qualifier.
`default_nettype none
package bea_pkg;

    localparam int unsigned PORTS_DEF = 4;

    localparam logic [15:0] INIT_DELAY_RST = 16'd30;
    localparam logic [15:0] INTERVAL_RST   = 16'd5;

    // Register indexes (paddr[2])
    localparam logic REG_INIT_DELAY = 1'b0;
    localparam logic REG_INTERVAL   = 1'b1;

    // Request kinds (tuser)
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // Per-port state entry
    typedef struct packed {
        logic        err;
        logic [15:0] sticky_rep;
        logic [15:0] sticky_rel;
        logic [15:0] sticky_pr;
        logic [15:0] cnt;
        logic [7:0]  sy;
        logic [7:0]  sx;
        logic [15:0] held;
    } entry_t;

    localparam entry_t RST_ENTRY = '{
        err:        1'b1,
        sticky_rep: 16'd0,
        sticky_rel: 16'd0,
        sticky_pr:  16'd0,
        cnt:        INIT_DELAY_RST,
        sy:         8'd0,
        sx:         8'd0,
        held:       16'd0
    };

endpackage
`default_nettype wire

// ----- design/button_edge_autorepeat.sv -----
// Top level of the per-port button edge detector with auto-repeat.
//
// Usage:
//   Input stream (s_*): one request per accepted beat. s_tuser is the kind
//   (sample or flush); s_tdata carries port, read error, buttons, sticks.
//   Output stream (m_*): exactly one result per request, in request order.
//   APB port: register 0 at 0x0 is the initial delay, register 1 at 0x4 is
//   the repeat interval (paddr[2] selects, low bits ignored); write only
//   while no request is in flight.
//   Path: an accepted request and its memory read are registered in the
//   update stage, then its result in the output register, on m_tvalid.
//   Throughput: one request per cycle, any ports, bar output stalls. The port
//   state sits in a one-read one-write memory; the read-modify-write of the
//   entry spans the read cycle and the update cycle, and a one-entry bypass
//   of the last written entry covers back-to-back requests to one port.
//   Reset: ports start disconnected, buttons and sticks zero, counter 30;
//   per-port valid bits stand in for the memory contents, so no clear pass.
//   Stall: the output register holds its result while m_tready is low; one
//   more request may sit in the update stage, then s_tready drops.
`default_nettype none
`include "button_edge_autorepeat_macros.svh"
module button_edge_autorepeat #(
    parameter int unsigned PORTS = bea_pkg::PORTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // port[1:0], read_error[2], buttons[18:3], stick_x[26:19], stick_y[34:27]
    input  wire logic [39:0] s_tdata,
    // kind[0]
    input  wire logic [0:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_port[1:0], connected[2], held[18:3], pressed[34:19],
    // released[50:35], repeat_res[66:51], stick_x_out[74:67], stick_y_out[82:75]
    output logic      [87:0] m_tdata
);
    import bea_pkg::*;

    localparam int unsigned AW = (PORTS > 1) ? $clog2(PORTS) : 1;

    // ---------------- configuration ----------------
    logic [15:0] init_delay_reg;
    logic [15:0] interval_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_delay_reg <= INIT_DELAY_RST;
            interval_reg   <= INTERVAL_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_INIT_DELAY: init_delay_reg <= pwdata[15:0];
                REG_INTERVAL:   interval_reg   <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_INIT_DELAY: prdata = {16'd0, init_delay_reg};
            REG_INTERVAL:   prdata = {16'd0, interval_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- request decode ----------------
    logic          s_acc;
    logic [AW+1:0] in_port_ext;
    logic [AW-1:0] in_addr;
    logic          in_range;

    assign s_acc       = s_tvalid && s_tready;
    assign in_port_ext = {{AW{1'b0}}, s_tdata[1:0]};
    assign in_addr     = in_port_ext[AW-1:0];
    assign in_range    = in_port_ext < (AW + 2)'(PORTS);

    // ---------------- state memory and valid bits ----------------
    entry_t              mem [PORTS];
    entry_t              rd_data_reg;
    logic                rd_vld_reg;
    logic [PORTS-1:0]    vld_reg;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;

    // Read on accept, write back from the update stage
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            rd_data_reg <= mem[in_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_acc)
            begin
                rd_vld_reg <= in_range && vld_reg[in_addr];
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // ---------------- update stage ----------------
    logic        s1_vld_reg;
    logic        s1_kind_reg;
    logic [1:0]  s1_port_reg;
    logic        s1_range_reg;
    logic        s1_err_reg;
    logic [15:0] s1_btn_reg;
    logic [7:0]  s1_sx_reg;
    logic [7:0]  s1_sy_reg;
    logic        s1_go;

    assign s1_go    = s1_vld_reg && (!m_tvalid || m_tready);
    assign s_tready = !s1_vld_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_vld_reg <= s_tvalid;
        end
    end

    // Hold request payload alongside the memory read
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_kind_reg  <= s_tuser[0];
            s1_port_reg  <= s_tdata[1:0];
            s1_range_reg <= in_range;
            s1_err_reg   <= s_tdata[2];
            s1_btn_reg   <= s_tdata[18:3];
            s1_sx_reg    <= s_tdata[26:19];
            s1_sy_reg    <= s_tdata[34:27];
        end
    end

    // Bypass of the last written entry
    logic          wb_vld_reg;
    logic [AW-1:0] wb_addr_reg;
    entry_t        wb_data_reg;
    logic [AW+1:0] s1_port_ext;
    logic [AW-1:0] s1_addr;
    entry_t        cur;

    assign s1_port_ext = {{AW{1'b0}}, s1_port_reg};
    assign s1_addr     = s1_port_ext[AW-1:0];

    always_comb
    begin
        if (wb_vld_reg && (wb_addr_reg == s1_addr))
        begin
            cur = wb_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = RST_ENTRY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_vld_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            wb_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wb_addr_reg <= wr_addr;
            wb_data_reg <= wr_data;
        end
    end

    // Edge detect, repeat counter, sticky buffers
    logic [15:0] diff;
    logic [15:0] pr;
    logic [15:0] rl;
    logic [15:0] rp;
    logic [15:0] cnt_next;
    entry_t      nxt;
    logic        res_conn;
    logic [15:0] res_held;
    logic [15:0] res_pr;
    logic [15:0] res_rl;
    logic [15:0] res_rp;
    logic [7:0]  res_sx;
    logic [7:0]  res_sy;

    assign diff = s1_btn_reg ^ cur.held;
    assign pr   = diff & s1_btn_reg;
    assign rl   = diff & cur.held;

    always_comb
    begin
        if (diff != 16'd0)
        begin
            rp       = pr;
            cnt_next = init_delay_reg;
        end
        else if (cur.cnt > 16'd1)
        begin
            rp       = 16'd0;
            cnt_next = cur.cnt - 16'd1;
        end
        else
        begin
            rp       = s1_btn_reg;
            cnt_next = interval_reg;
        end
    end

    always_comb
    begin
        nxt      = cur;
        res_conn = 1'b0;
        res_held = 16'd0;
        res_pr   = 16'd0;
        res_rl   = 16'd0;
        res_rp   = 16'd0;
        res_sx   = 8'd0;
        res_sy   = 8'd0;
        case (s1_kind_reg)
            KIND_SAMPLE:
            begin
                nxt.err = s1_err_reg;
                if (!s1_err_reg)
                begin
                    nxt.held       = s1_btn_reg;
                    nxt.sx         = s1_sx_reg;
                    nxt.sy         = s1_sy_reg;
                    nxt.cnt        = cnt_next;
                    nxt.sticky_pr  = cur.sticky_pr | pr;
                    nxt.sticky_rel = cur.sticky_rel | rl;
                    nxt.sticky_rep = cur.sticky_rep | rp;
                    res_conn       = 1'b1;
                    res_held       = s1_btn_reg;
                    res_pr         = pr;
                    res_rl         = rl;
                    res_rp         = rp;
                    res_sx         = s1_sx_reg;
                    res_sy         = s1_sy_reg;
                end
            end
            KIND_FLUSH:
            begin
                nxt.sticky_pr  = 16'd0;
                nxt.sticky_rel = 16'd0;
                nxt.sticky_rep = 16'd0;
                if (!cur.err)
                begin
                    res_conn = 1'b1;
                    res_held = cur.held;
                    res_pr   = cur.sticky_pr;
                    res_rl   = cur.sticky_rel;
                    res_rp   = cur.sticky_rep;
                    res_sx   = cur.sx;
                    res_sy   = cur.sy;
                end
            end
            default: ;
        endcase
        // Drop everything for a port beyond the array
        if (!s1_range_reg)
        begin
            res_conn = 1'b0;
            res_held = 16'd0;
            res_pr   = 16'd0;
            res_rl   = 16'd0;
            res_rp   = 16'd0;
            res_sx   = 8'd0;
            res_sy   = 8'd0;
        end
    end

    assign wr_en   = s1_go && s1_range_reg;
    assign wr_addr = s1_addr;
    assign wr_data = nxt;

    // ---------------- output register ----------------
    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            m_tdata_reg <= {5'd0, res_sy, res_sx, res_rp, res_rl, res_pr,
                            res_held, res_conn, s1_port_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------
    `BEA_ASSERT_IMP(a_wr_from_stage, wr_en, s1_vld_reg && s1_range_reg)
    `BEA_ASSERT_NXT(a_wr_bypass, wr_en, wb_vld_reg && (wb_addr_reg == $past(wr_addr)) && vld_reg[$past(wr_addr)])
    `BEA_ASSERT_NXT(a_stage_hold, s1_vld_reg && !s1_go, s1_vld_reg && $stable(s1_btn_reg))
    `BEA_ASSERT_IMP(a_disc_zero, m_tvalid && !m_tdata[2], m_tdata[87:3] == 85'd0)

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the button edge / auto-repeat qualifier.
`timescale 1ns / 100ps
module tb_top;
    import bea_pkg::*;

    localparam int PORT_CNT = 4;

    // Request fields as packed into s_tdata, port in the lowest bits
    typedef struct packed {
        logic [7:0]  sy;
        logic [7:0]  sx;
        logic [15:0] btn;
        logic        err;
        logic [1:0]  port;
    } pad_sample_t;

    typedef struct packed {
        logic        kind;
        pad_sample_t sample;
    } pad_request_t;

    // Result fields as packed into m_tdata, out_port in the lowest bits
    typedef struct packed {
        logic [7:0]  sy;
        logic [7:0]  sx;
        logic [15:0] rep;
        logic [15:0] rel;
        logic [15:0] pr;
        logic [15:0] held;
        logic        connected;
        logic [1:0]  port;
    } pad_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    button_edge_autorepeat u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // Pending requests and the results they should produce
    pad_request_t pending_reqs[$];
    pad_result_t  expected_results[$];
    int           mismatch_cnt = 0;
    int           reqs_taken = 0;
    logic         req_taken = 1'b0;

    // Shadow of the per-port state and the registers
    logic [15:0] held_st[PORT_CNT];
    logic [7:0]  sx_st[PORT_CNT];
    logic [7:0]  sy_st[PORT_CNT];
    int          rpt_cnt[PORT_CNT];
    logic [15:0] sticky_pr[PORT_CNT];
    logic [15:0] sticky_rel[PORT_CNT];
    logic [15:0] sticky_rep[PORT_CNT];
    logic        port_fault[PORT_CNT];
    int          cfg_delay;
    int          cfg_interval;

    // Stimulus generator state
    int          gen_port = 0;
    logic [15:0] gen_btn[PORT_CNT];

    // Receiver hold-off and no-idle window
    int   hold_left = 0;
    logic hold_done = 1'b0;
    wire  burst_win = (reqs_taken >= 500) && (reqs_taken < 700);

    // Work out the result of one request and advance the shadow state
    function automatic pad_result_t predict_result(input logic kind, input pad_sample_t s);
        pad_result_t r;
        logic [15:0] old_btn;
        logic [15:0] diff;
        logic [15:0] pr;
        logic [15:0] rl;
        logic [15:0] rp;
        int          p;
        r = '0;
        r.port = s.port;
        p = s.port;
        if (kind == KIND_SAMPLE) begin
            port_fault[p] = s.err;
            if (!s.err) begin
                old_btn = held_st[p];
                diff = s.btn ^ old_btn;
                pr = diff & s.btn;
                rl = diff & old_btn;
                if (diff != 16'd0) begin
                    rp = pr;
                    rpt_cnt[p] = cfg_delay;
                end
                else begin
                    rpt_cnt[p] = rpt_cnt[p] - 1;
                    if (rpt_cnt[p] > 0) begin
                        rp = 16'd0;
                    end
                    else begin
                        rp = s.btn;
                        rpt_cnt[p] = cfg_interval;
                    end
                end
                held_st[p] = s.btn;
                sx_st[p] = s.sx;
                sy_st[p] = s.sy;
                sticky_pr[p] |= pr;
                sticky_rel[p] |= rl;
                sticky_rep[p] |= rp;
                r.connected = 1'b1;
                r.held = s.btn;
                r.pr = pr;
                r.rel = rl;
                r.rep = rp;
                r.sx = s.sx;
                r.sy = s.sy;
            end
        end
        else begin
            if (!port_fault[p]) begin
                r.connected = 1'b1;
                r.held = held_st[p];
                r.pr = sticky_pr[p];
                r.rel = sticky_rel[p];
                r.rep = sticky_rep[p];
                r.sx = sx_st[p];
                r.sy = sy_st[p];
            end
            sticky_pr[p] = 16'd0;
            sticky_rel[p] = 16'd0;
            sticky_rep[p] = 16'd0;
        end
        return r;
    endfunction

    task automatic push_req(input logic kind, input logic [1:0] port, input logic err,
                            input logic [15:0] btn, input logic [7:0] sx, input logic [7:0] sy);
        pad_request_t q;
        q.kind = kind;
        q.sample.port = port;
        q.sample.err = err;
        q.sample.btn = btn;
        q.sample.sx = sx;
        q.sample.sy = sy;
        pending_reqs.push_back(q);
    endtask

    // Mostly steady buttons on a favored port, with flushes, errors and changes mixed in
    task automatic queue_random(input int n);
        logic        err;
        logic [15:0] btn;
        int          pick;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) >= 70)
                gen_port = $urandom_range(PORT_CNT - 1);
            if ($urandom_range(99) < 12) begin
                push_req(KIND_FLUSH, 2'(gen_port), 1'($urandom), 16'($urandom),
                         8'($urandom), 8'($urandom));
            end
            else begin
                err = ($urandom_range(99) < 6);
                pick = $urandom_range(99);
                if (pick < 10)
                    btn = 16'($urandom);
                else if (pick < 22)
                    btn = gen_btn[gen_port] ^ (16'd1 << $urandom_range(15));
                else
                    btn = gen_btn[gen_port];
                if (!err)
                    gen_btn[gen_port] = btn;
                push_req(KIND_SAMPLE, 2'(gen_port), err, btn, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Wait until every request is sent and every result is back
    task automatic wait_drained;
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, release
    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_INIT_DELAY)
            cfg_delay = int'(val);
        else
            cfg_interval = int'(val);
    endtask

    task automatic run_phase(input logic [15:0] delay, input logic [15:0] interval, input int n);
        wait_drained();
        write_reg(REG_INIT_DELAY, delay);
        write_reg(REG_INTERVAL, interval);
        queue_random(n);
    endtask

    // Offer the next request once the current one is taken, idling at random
    always @(negedge clk) begin : drive_requests
        pad_request_t nxt;
        logic         offer;
        if (rst_n && (!s_tvalid || req_taken)) begin
            offer = 1'b0;
            nxt = '0;
            if (pending_reqs.size() != 0 && (burst_win || $urandom_range(99) >= 37)) begin
                nxt = pending_reqs.pop_front();
                offer = 1'b1;
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tuser <= nxt.kind;
                s_tdata <= {5'd0, nxt.sample};
            end
        end
    end

    // Drive result ready: one long hold-off, otherwise random stalls
    always @(negedge clk) begin : drive_ready
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (!hold_done && reqs_taken >= 300) begin
                hold_left <= 150;
                hold_done <= 1'b1;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= burst_win || ($urandom_range(99) >= 37);
            end
        end
    end

    // Check each result against the oldest expectation, then predict new requests
    always @(posedge clk) begin : watch_streams
        pad_result_t got;
        pad_result_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[82:0];
                if (expected_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("Unexpected result: %h", got);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.port !== want.port || got.connected !== want.connected ||
                        got.held !== want.held || got.pr !== want.pr ||
                        got.rel !== want.rel || got.rep !== want.rep ||
                        got.sx !== want.sx || got.sy !== want.sy) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"Mismatch port %0d: expected conn %b held %h pr %h ",
                                      "rel %h rep %h sx %h sy %h, got conn %b held %h pr %h ",
                                      "rel %h rep %h sx %h sy %h port %0d"},
                                     want.port, want.connected, want.held, want.pr,
                                     want.rel, want.rep, want.sx, want.sy, got.connected,
                                     got.held, got.pr, got.rel, got.rep, got.sx, got.sy,
                                     got.port);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_result(s_tuser[0], s_tdata[34:0]));
                reqs_taken <= reqs_taken + 1;
            end
            req_taken <= s_tvalid && s_tready;
        end
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        cfg_delay = int'(INIT_DELAY_RST);
        cfg_interval = int'(INTERVAL_RST);
        for (int p = 0; p < PORT_CNT; p++) begin
            held_st[p] = '0;
            sx_st[p] = '0;
            sy_st[p] = '0;
            rpt_cnt[p] = int'(INIT_DELAY_RST);
            sticky_pr[p] = '0;
            sticky_rel[p] = '0;
            sticky_rep[p] = '0;
            port_fault[p] = 1'b1;
            gen_btn[p] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Flush of a port still in error after reset, fields ignored
        push_req(KIND_FLUSH, 2'd0, 1'b1, 16'hFFFF, 8'h7F, 8'h80);
        // Error sample, then flush of the failed port
        push_req(KIND_SAMPLE, 2'd1, 1'b1, 16'hFFFF, 8'h80, 8'h7F);
        push_req(KIND_FLUSH, 2'd1, 1'b0, 16'h0000, 8'h00, 8'h00);
        // All pressed, all released, then unchanged
        push_req(KIND_SAMPLE, 2'd0, 1'b0, 16'hFFFF, 8'h7F, 8'h80);
        push_req(KIND_SAMPLE, 2'd0, 1'b0, 16'h0000, 8'h80, 8'h7F);
        push_req(KIND_SAMPLE, 2'd0, 1'b0, 16'h0000, 8'hFF, 8'h01);
        // Flush returns the buffers, a second flush sees them cleared
        push_req(KIND_FLUSH, 2'd0, 1'b1, 16'h5A5A, 8'h12, 8'h34);
        push_req(KIND_FLUSH, 2'd0, 1'b0, 16'hA5A5, 8'h56, 8'h78);
        // Error after a good sample keeps state but reports disconnected
        push_req(KIND_SAMPLE, 2'd2, 1'b0, 16'h00A5, 8'h10, 8'hF0);
        push_req(KIND_SAMPLE, 2'd2, 1'b1, 16'h1234, 8'h20, 8'hE0);
        push_req(KIND_FLUSH, 2'd2, 1'b0, 16'h0000, 8'h00, 8'h00);
        push_req(KIND_SAMPLE, 2'd2, 1'b0, 16'h00A5, 8'h30, 8'hD0);
        push_req(KIND_FLUSH, 2'd2, 1'b0, 16'h0000, 8'h00, 8'h00);
        // Interleave ports in consecutive requests
        push_req(KIND_SAMPLE, 2'd3, 1'b0, 16'h8001, 8'h01, 8'hFE);
        push_req(KIND_SAMPLE, 2'd1, 1'b0, 16'h5555, 8'h7F, 8'h7F);
        push_req(KIND_SAMPLE, 2'd3, 1'b0, 16'h7FFE, 8'h80, 8'h80);
        push_req(KIND_SAMPLE, 2'd1, 1'b0, 16'hAAAA, 8'h00, 8'h00);
        push_req(KIND_SAMPLE, 2'd3, 1'b0, 16'h7FFE, 8'h55, 8'hAA);
        push_req(KIND_SAMPLE, 2'd3, 1'b0, 16'h7FFE, 8'hAA, 8'h55);
        push_req(KIND_FLUSH, 2'd1, 1'b0, 16'hFFFF, 8'hFF, 8'hFF);
        push_req(KIND_FLUSH, 2'd3, 1'b1, 16'hFFFF, 8'hFF, 8'hFF);
        gen_btn[0] = 16'h0000;
        gen_btn[1] = 16'hAAAA;
        gen_btn[2] = 16'h00A5;
        gen_btn[3] = 16'h7FFE;

        // Random traffic under a series of register settings
        queue_random(200);
        run_phase(16'd0, 16'd0, 150);
        run_phase(16'hFFFF, 16'hFFFF, 100);
        run_phase(16'd1, 16'd3, 150);
        run_phase(16'd2, 16'd0, 100);
        run_phase(16'($urandom_range(40)), 16'($urandom_range(10)), 150);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
